[rtl/mfir_pkg.sv]
// Shared types, constants and helpers of the multichannel low-pass FIR.
package mfir_pkg;

  localparam int CHANNELS     = 64;
  localparam int TAPS         = 10;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CHAN_W       = 6;
  localparam int COEF_W       = 15;
  localparam int COEF_REGS    = 5;
  localparam int FRAC_BITS    = 15;

  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_W      = $clog2(TAPS + 1);
  localparam int CI_W       = $clog2(COEF_REGS);
  localparam int HIST_DEPTH = CHANNELS * TAPS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int PROD_W     = SAMPLE_WIDTH + COEF_W + 2;
  localparam int ACC_W      = PROD_W + 4;
  localparam int CFG_AW     = 3;

  typedef logic [COEF_REGS-1:0][COEF_W-1:0] coef_arr_t;

  // Coefficient register indexes on the configuration port
  typedef enum logic [CFG_AW-1:0] {
    CFG_COEF_OUTER  = 3'd0,
    CFG_COEF_SECOND = 3'd1,
    CFG_COEF_THIRD  = 3'd2,
    CFG_COEF_FOURTH = 3'd3,
    CFG_COEF_CENTER = 3'd4
  } cfg_reg_t;

  localparam coef_arr_t COEF_RESET = {15'd6452, 15'd5109, 15'd3051, 15'd1243, 15'd529};

  // One classified input item on its way to the filter engine
  typedef struct packed {
    logic [CH_AW-1:0]               ch_idx;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           in_range;
  } job_t;

  // Coefficient register that serves tap k: mirrored across the taps
  function automatic logic [CI_W-1:0] coef_sel(input logic [TAP_W-1:0] k);
    int kk;
    int mm;
    int ci;
    kk = int'(k);
    mm = TAPS - 1 - kk;
    ci = (kk < mm) ? kk : mm;
    if (ci >= COEF_REGS) ci = COEF_REGS - 1;
    if (ci < 0) ci = 0;
    return CI_W'(ci);
  endfunction

endpackage

[rtl/mfir_front.sv]
// Input side: accept items, classify the channel, buffer them in a short queue.
module mfir_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  logic [mfir_pkg::CHAN_W-1:0]            in_channel,
  input  logic signed [mfir_pkg::SAMPLE_WIDTH-1:0] in_sample,
  output logic                                   job_valid,
  output mfir_pkg::job_t                         job,
  input  logic                                   job_pop
);

  mfir_pkg::job_t q_r [2];
  logic           head_r, head_nxt;
  logic           tail_r, tail_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;
  mfir_pkg::job_t new_job;

  assign full      = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[head_r];
  assign do_push   = push && !full;
  assign do_pop    = job_pop && job_valid;

  // Classify: flag channels beyond the configured count
  always_comb begin
    new_job.ch_idx   = mfir_pkg::CH_AW'(in_channel);
    new_job.sample   = in_sample;
    new_job.in_range = (int'(in_channel) < mfir_pkg::CHANNELS);
  end

  // Advance queue pointers
  always_comb begin
    head_nxt = do_pop ? ~head_r : head_r;
    tail_nxt = do_push ? ~tail_r : tail_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold queued items
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[tail_r] <= new_job;
    end
  end

endmodule

[rtl/mfir_back.sv]
// Filter engine: per-channel history memory, multiply-accumulate sequencer, result queue.
module mfir_back (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  mfir_pkg::coef_arr_t                      coef,
  input  logic                                     job_valid,
  input  mfir_pkg::job_t                           job,
  output logic                                     job_pop,
  output logic                                     empty,
  input  logic                                     pop,
  output logic signed [mfir_pkg::SAMPLE_WIDTH-1:0] out_filtered
);

  localparam int SW = mfir_pkg::SAMPLE_WIDTH;
  localparam int AW = mfir_pkg::ACC_W;
  localparam int TW = mfir_pkg::TAP_W;
  localparam logic signed [AW-1:0] SAT_HI   = AW'(2 ** (SW - 1) - 1);
  localparam logic signed [AW-1:0] SAT_LO   = AW'(-(2 ** (SW - 1)));
  localparam logic signed [AW-1:0] HALF_LSB = AW'(2 ** (mfir_pkg::FRAC_BITS - 1));

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PTR, S_RUN, S_OUT} state_t;

  // Storage
  logic signed [SW-1:0] hist_mem [mfir_pkg::HIST_DEPTH];
  logic [TW-1:0]        ptr_mem  [mfir_pkg::CHANNELS];

  state_t                          state_r;
  logic [mfir_pkg::HIST_AW-1:0]    clr_addr_r;
  mfir_pkg::job_t                  job_r;
  logic [mfir_pkg::HIST_AW-1:0]    base_r;
  logic [TW-1:0]                   ptr_rd_r;
  logic signed [SW-1:0]            rd_data_r;
  logic [TW-1:0]                   issue_k_r;
  logic [TW-1:0]                   pos_r;
  logic                            issuing_r;
  logic                            s1_valid_r;
  logic                            s1_sel_x_r;
  logic [mfir_pkg::CI_W-1:0]       s1_ci_r;
  logic                            p_valid_r;
  logic signed [mfir_pkg::PROD_W-1:0] prod_r;
  logic signed [AW-1:0]            acc_r;
  logic [TW-1:0]                   acc_cnt_r;

  logic signed [SW-1:0] out_q_r [2];
  logic                 out_rd_r, out_wr_r;
  logic [1:0]           out_cnt_r;

  logic                            take;
  logic [TW-1:0]                   n_pos;
  logic [TW-1:0]                   n_next;
  logic [TW-1:0]                   n_prev;
  logic [mfir_pkg::HIST_AW-1:0]    wr_addr;
  logic [mfir_pkg::HIST_AW-1:0]    rd_addr;
  logic                            hist_we;
  logic signed [SW-1:0]            hist_wdata;
  logic                            clr_ptr;
  logic signed [SW-1:0]            tap_sample;
  logic signed [AW-1:0]            rsum;
  logic signed [AW-1:0]            y_wide;
  logic signed [SW-1:0]            y_sat;
  logic                            res_push;
  logic signed [SW-1:0]            res_val;
  logic                            res_pop;

  // Take a job only while a result slot is free
  assign take    = (state_r == S_IDLE) && job_valid && (out_cnt_r != 2'd2);
  assign job_pop = take;

  // Current write position, reduced into range, and its neighbors
  always_comb begin
    n_pos  = (ptr_rd_r >= TW'(mfir_pkg::TAPS)) ? ptr_rd_r - TW'(mfir_pkg::TAPS) : ptr_rd_r;
    n_next = (n_pos == TW'(mfir_pkg::TAPS - 1)) ? '0 : n_pos + TW'(1);
    n_prev = (n_pos == '0) ? TW'(mfir_pkg::TAPS - 1) : n_pos - TW'(1);
  end

  // History write and read addresses
  always_comb begin
    hist_we    = (state_r == S_CLEAR) || (state_r == S_PTR);
    hist_wdata = (state_r == S_CLEAR) ? '0 : job_r.sample;
    wr_addr    = (state_r == S_CLEAR) ? clr_addr_r : base_r + mfir_pkg::HIST_AW'(n_pos);
    rd_addr    = base_r + mfir_pkg::HIST_AW'(pos_r);
    clr_ptr    = (state_r == S_CLEAR) && (int'(clr_addr_r) < mfir_pkg::CHANNELS);
  end

  // History memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wr_addr] <= hist_wdata;
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  // Write pointer memory: cleared in the sweep, bumped once per in-range item
  always_ff @(posedge clk) begin
    if (clr_ptr) begin
      ptr_mem[mfir_pkg::CH_AW'(clr_addr_r)] <= '0;
    end else if (state_r == S_PTR) begin
      ptr_mem[job_r.ch_idx] <= n_next;
    end
    ptr_rd_r <= ptr_mem[job.ch_idx];
  end

  // Latch the job and its history base
  always_ff @(posedge clk) begin
    if (take) begin
      job_r  <= job;
      base_r <= mfir_pkg::HIST_AW'(int'(job.ch_idx) * mfir_pkg::TAPS);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      issuing_r  <= 1'b0;
      issue_k_r  <= '0;
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_sel_x_r <= 1'b0;
      s1_ci_r    <= '0;
      acc_cnt_r  <= '0;
    end else begin
      s1_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + mfir_pkg::HIST_AW'(1);
          if (int'(clr_addr_r) == mfir_pkg::HIST_DEPTH - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take && job.in_range) begin
            state_r <= S_PTR;
          end
        end
        S_PTR: begin
          s1_valid_r <= 1'b1;
          s1_sel_x_r <= 1'b1;
          s1_ci_r    <= mfir_pkg::coef_sel('0);
          issue_k_r  <= TW'(1);
          pos_r      <= n_prev;
          issuing_r  <= 1'b1;
          acc_cnt_r  <= '0;
          state_r    <= S_RUN;
        end
        S_RUN: begin
          if (issuing_r) begin
            s1_valid_r <= 1'b1;
            s1_sel_x_r <= 1'b0;
            s1_ci_r    <= mfir_pkg::coef_sel(issue_k_r);
            issue_k_r  <= issue_k_r + TW'(1);
            pos_r      <= (pos_r == '0) ? TW'(mfir_pkg::TAPS - 1) : pos_r - TW'(1);
            if (issue_k_r == TW'(mfir_pkg::TAPS - 1)) begin
              issuing_r <= 1'b0;
            end
          end
          if (p_valid_r) begin
            acc_cnt_r <= acc_cnt_r + TW'(1);
            if (acc_cnt_r == TW'(mfir_pkg::TAPS - 1)) begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Multiply stage then accumulate stage
  assign tap_sample = s1_sel_x_r ? job_r.sample : rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, coef[s1_ci_r]}) * tap_sample;
    if (state_r == S_PTR) begin
      acc_r <= '0;
    end else if (p_valid_r) begin
      acc_r <= acc_r + AW'(prod_r);
    end
  end

  // Round half up, then clamp to the sample range
  always_comb begin
    rsum   = acc_r + HALF_LSB;
    y_wide = rsum >>> mfir_pkg::FRAC_BITS;
    if (y_wide > SAT_HI) begin
      y_sat = SW'(SAT_HI);
    end else if (y_wide < SAT_LO) begin
      y_sat = SW'(SAT_LO);
    end else begin
      y_sat = SW'(y_wide);
    end
  end

  // Result queue: out-of-range items give zero at once
  assign res_push     = (state_r == S_OUT) || (take && !job.in_range);
  assign res_val      = (state_r == S_OUT) ? y_sat : '0;
  assign empty        = (out_cnt_r == 2'd0);
  assign res_pop      = pop && !empty;
  assign out_filtered = out_q_r[out_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_rd_r  <= 1'b0;
      out_wr_r  <= 1'b0;
      out_cnt_r <= 2'd0;
    end else begin
      if (res_push) out_wr_r <= ~out_wr_r;
      if (res_pop)  out_rd_r <= ~out_rd_r;
      out_cnt_r <= out_cnt_r + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_q_r[out_wr_r] <= res_val;
    end
  end

endmodule

[rtl/multichannel_fir_lowpass_unit.sv]
// Top level of the multichannel ten-tap symmetric low-pass FIR.
// Each item carries a channel and a signed sample; the sample replaces the
// oldest of that channel's ten stored samples and the result is the rounded,
// saturated Q1.15 sum over the newest ten. Items queue in a two-entry input
// buffer and results in a two-entry output buffer, so both sides may stall on
// their own. In the filter engine an item on a valid channel goes through
// one pointer read, one history write, nine history reads through the single
// memory read port feeding one multiplier and accumulator (two-stage
// pipeline), and an output state. An item on a channel beyond the channel
// count skips the filter and returns zero. After reset the engine sweeps all
// 640 history entries (one entry per cycle) before it starts on items; items
// are queued and coefficient writes are taken during the sweep.
module multichannel_fir_lowpass_unit (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     push,
  output logic                                     full,
  input  logic [mfir_pkg::CHAN_W-1:0]              in_channel,
  input  logic signed [mfir_pkg::SAMPLE_WIDTH-1:0] in_sample,
  output logic                                     empty,
  input  logic                                     pop,
  output logic signed [mfir_pkg::SAMPLE_WIDTH-1:0] out_filtered,
  input  logic                                     cfg_we,
  input  logic [mfir_pkg::CFG_AW-1:0]              cfg_addr,
  input  logic [mfir_pkg::COEF_W-1:0]              cfg_wdata
);

  mfir_pkg::coef_arr_t coef_r;
  logic                job_valid;
  mfir_pkg::job_t      job;
  logic                job_pop;

  // Coefficient registers; writes beyond the list drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= mfir_pkg::COEF_RESET;
    end else if (cfg_we) begin
      unique case (mfir_pkg::cfg_reg_t'(cfg_addr))
        mfir_pkg::CFG_COEF_OUTER:  coef_r[0] <= cfg_wdata;
        mfir_pkg::CFG_COEF_SECOND: coef_r[1] <= cfg_wdata;
        mfir_pkg::CFG_COEF_THIRD:  coef_r[2] <= cfg_wdata;
        mfir_pkg::CFG_COEF_FOURTH: coef_r[3] <= cfg_wdata;
        mfir_pkg::CFG_COEF_CENTER: coef_r[4] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mfir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_channel(in_channel),
    .in_sample (in_sample),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  mfir_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .coef        (coef_r),
    .job_valid   (job_valid),
    .job         (job),
    .job_pop     (job_pop),
    .empty       (empty),
    .pop         (pop),
    .out_filtered(out_filtered)
  );

endmodule
